>>> src/ppc_pkg.sv
// ppc_pkg: shared types and constants of the polygon plane clipper
// used by the interfaces, the front, the queue, the back and the top level
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DOT_W     = 64;
  localparam int unsigned ACC_W     = 66;
  localparam int unsigned T_W       = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned Q_DEPTH   = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_A = 3'd0,
    REG_PLANE_B = 3'd1,
    REG_PLANE_C = 3'd2,
    REG_PLANE_D = 3'd3
  } cfg_reg_e;

  typedef logic [3:0][COORD_W-1:0] vec_t;

  // one classified vertex with the edge ends it needs
  typedef struct packed {
    vec_t             cur;
    logic [DOT_W-1:0] cur_dot;
    vec_t             prv;
    logic [DOT_W-1:0] prv_dot;
    vec_t             fst;
    logic [DOT_W-1:0] fst_dot;
    logic             mid;
    logic             fin;
  } job_t;

endpackage

>>> src/ppc_if.sv
// ppc_if: handshake channels of the polygon plane clipper
// depends on ppc_pkg for widths
`timescale 1ns / 1ps
interface ppc_vtx_if;
  logic                        valid;
  logic                        ready;
  logic [ppc_pkg::COORD_W-1:0] in_x;
  logic [ppc_pkg::COORD_W-1:0] in_y;
  logic [ppc_pkg::COORD_W-1:0] in_z;
  logic [ppc_pkg::COORD_W-1:0] in_w;
  logic                        final_vertex;
  modport source (output valid, in_x, in_y, in_z, in_w, final_vertex, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, final_vertex, output ready);
endinterface

interface ppc_res_if;
  logic                        valid;
  logic                        ready;
  logic [ppc_pkg::COORD_W-1:0] out_x;
  logic [ppc_pkg::COORD_W-1:0] out_y;
  logic [ppc_pkg::COORD_W-1:0] out_z;
  logic [ppc_pkg::COORD_W-1:0] out_w;
  logic                        vertex_present;
  logic                        polygon_done;
  logic                        polygon_kept;
  logic                        run_end;
  modport source (output valid, out_x, out_y, out_z, out_w, vertex_present,
                  polygon_done, polygon_kept, run_end, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, vertex_present,
                polygon_done, polygon_kept, run_end, output ready);
endinterface

interface ppc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppc_pkg::CFG_IDX_W-1:0] index;
  logic [ppc_pkg::COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/ppc_front.sv
// ppc_front: takes vertex requests, forms the plane dot product, pushes jobs
// depends on ppc_pkg and ppc_if; holds the plane registers and polygon state
`timescale 1ns / 1ps
module ppc_front #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ppc_vtx_if.sink         vtx,
  ppc_cfg_if.sink         cfg,
  input  logic            q_full_i,
  output logic            q_wr_o,
  output ppc_pkg::job_t   q_data_o
);

  typedef enum logic [1:0] {F_IDLE, F_MAC, F_PUSH} fstate_e;

  fstate_e                            state_q;
  logic [2:0]                         cnt_q;
  logic                               mid_q;
  logic [3:0][ppc_pkg::COORD_W-1:0]   plane_q;
  ppc_pkg::vec_t                      vec_q, prv_q, fst_q;
  logic                               fin_q;
  logic signed [ppc_pkg::DOT_W-1:0]   prod_q;
  logic signed [ppc_pkg::ACC_W-1:0]   acc_q;
  logic [ppc_pkg::DOT_W-1:0]          prv_dot_q, fst_dot_q;
  logic [ppc_pkg::DOT_W-1:0]          dot;
  logic                               accept, push;

  function automatic logic [ppc_pkg::COORD_W-1:0] sx(input logic [ppc_pkg::COORD_W-1:0] v);
    logic signed [COORD_WIDTH-1:0] n;
    n = v[COORD_WIDTH-1:0];
    return ppc_pkg::COORD_W'(n);
  endfunction

  assign vtx.ready = (state_q == F_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = vtx.valid && vtx.ready;
  assign push      = (state_q == F_PUSH) && !q_full_i;
  assign q_wr_o    = push;

  // saturate the exact sum to 64 bits
  always_comb begin
    if (acc_q[65:63] == 3'b000 || acc_q[65:63] == 3'b111) begin
      dot = acc_q[63:0];
    end else if (acc_q[65]) begin
      dot = {1'b1, {(ppc_pkg::DOT_W-1){1'b0}}};
    end else begin
      dot = {1'b0, {(ppc_pkg::DOT_W-1){1'b1}}};
    end
  end

  // job towards the back
  always_comb begin
    q_data_o.cur     = vec_q;
    q_data_o.cur_dot = dot;
    q_data_o.prv     = prv_q;
    q_data_o.prv_dot = prv_dot_q;
    q_data_o.fst     = mid_q ? fst_q : vec_q;
    q_data_o.fst_dot = mid_q ? fst_dot_q : dot;
    q_data_o.mid     = mid_q;
    q_data_o.fin     = fin_q;
  end

  // sequencer and plane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      mid_q   <= 1'b0;
      plane_q <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          ppc_pkg::REG_PLANE_A: plane_q[0] <= cfg.data;
          ppc_pkg::REG_PLANE_B: plane_q[1] <= cfg.data;
          ppc_pkg::REG_PLANE_C: plane_q[2] <= cfg.data;
          ppc_pkg::REG_PLANE_D: plane_q[3] <= cfg.data;
          default: ;
        endcase
      end
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            state_q <= F_MAC;
            cnt_q   <= '0;
          end
        end
        F_MAC: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push) begin
            state_q <= F_IDLE;
            mid_q   <= !fin_q;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // vertex, products and polygon ends
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vec_q[0] <= sx(vtx.in_x);
      vec_q[1] <= sx(vtx.in_y);
      vec_q[2] <= sx(vtx.in_z);
      vec_q[3] <= sx(vtx.in_w);
      fin_q    <= vtx.final_vertex;
      acc_q    <= '0;
    end
    if (state_q == F_MAC) begin
      if (cnt_q != 3'd4) begin
        prod_q <= $signed(plane_q[cnt_q[1:0]]) * $signed(vec_q[cnt_q[1:0]]);
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + ppc_pkg::ACC_W'(prod_q);
      end
    end
    if (push) begin
      prv_q     <= vec_q;
      prv_dot_q <= dot;
      if (!mid_q) begin
        fst_q     <= vec_q;
        fst_dot_q <= dot;
      end
    end
  end

endmodule

>>> src/ppc_queue.sv
// ppc_queue: two-entry job queue between front and back
// depends on ppc_pkg for the job type
`timescale 1ns / 1ps
module ppc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  ppc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          rd_i,
  output ppc_pkg::job_t data_o,
  output logic          empty_o
);

  ppc_pkg::job_t mem_q [ppc_pkg::Q_DEPTH];
  logic          wp_q, rp_q;
  logic [1:0]    fill_q;

  assign full_o  = (fill_q == 2'(ppc_pkg::Q_DEPTH));
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
      if (wr_i && !rd_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (rd_i && !wr_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= data_i;
  end

endmodule

>>> src/ppc_back.sv
// ppc_back: walks the edges of each job, divides and interpolates crossings
// depends on ppc_pkg and ppc_if; drives the result register
`timescale 1ns / 1ps
module ppc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  ppc_pkg::job_t q_data_i,
  output logic          q_rd_o,
  ppc_res_if.source     res
);

  typedef enum logic [2:0] {B_IDLE, B_RUN, B_DIV, B_MUL, B_ADD} bstate_e;

  // step codes, one bit each in the step mask
  localparam int unsigned E1_START = 0;
  localparam int unsigned E1_CROSS = 1;
  localparam int unsigned E2_START = 2;
  localparam int unsigned E2_CROSS = 3;
  localparam int unsigned STATUS   = 4;

  bstate_e                          state_q;
  logic [4:0]                       mask_q;
  logic [1:0]                       cnt_q;
  logic                             xrdy_q;
  logic [4:0]                       bit_q;
  logic [1:0]                       j_q;
  logic                             vld_q;
  ppc_pkg::job_t                    job_q;
  ppc_pkg::vec_t                    ov_q, iv_q, xr_q, ovec_q;
  logic [ppc_pkg::DOT_W-1:0]        rem_q, den_q;
  logic [ppc_pkg::T_W-1:0]          t_q;
  logic signed [57:0]               prod_q;
  logic                             pres_q, done_q, kept_q, end_q;

  logic [4:0]                       mask_in, mask_nxt, sel;
  logic                             pop, out_free, emit, need_div, pres;
  logic [1:0]                       cnt_nxt;
  ppc_pkg::vec_t                    evec, av, bv;
  logic [ppc_pkg::DOT_W-1:0]        da, db;
  logic [ppc_pkg::DOT_W:0]          rem_sh;
  logic                             take;
  logic [ppc_pkg::COORD_W-1:0]      qv;

  function automatic logic neg(input logic [ppc_pkg::DOT_W-1:0] d);
    return d[ppc_pkg::DOT_W-1];
  endfunction
  function automatic logic pos(input logic [ppc_pkg::DOT_W-1:0] d);
    return !d[ppc_pkg::DOT_W-1] && (d != '0);
  endfunction

  // step mask of an incoming job
  always_comb begin
    mask_in           = '0;
    mask_in[E1_START] = q_data_i.mid && !neg(q_data_i.prv_dot);
    mask_in[E1_CROSS] = q_data_i.mid &&
                        ((neg(q_data_i.prv_dot) && pos(q_data_i.cur_dot)) ||
                         (pos(q_data_i.prv_dot) && neg(q_data_i.cur_dot)));
    mask_in[E2_START] = q_data_i.fin && !neg(q_data_i.cur_dot);
    mask_in[E2_CROSS] = q_data_i.fin &&
                        ((neg(q_data_i.cur_dot) && pos(q_data_i.fst_dot)) ||
                         (pos(q_data_i.cur_dot) && neg(q_data_i.fst_dot)));
    mask_in[STATUS]   = q_data_i.fin && (mask_in[3:0] == 4'd0);
  end

  // lowest pending step and what it emits
  always_comb begin
    sel      = mask_q & (~mask_q + 5'd1);
    mask_nxt = mask_q & ~sel;
    need_div = (sel[E1_CROSS] || sel[E2_CROSS]) && !xrdy_q;
    out_free = !vld_q || res.ready;
    emit     = (state_q == B_RUN) && !need_div && out_free;
    pop      = (state_q == B_IDLE) && !q_empty_i;
    pres     = !sel[STATUS];
    cnt_nxt  = (pres && cnt_q != 2'd3) ? cnt_q + 2'd1 : cnt_q;
    if (sel[E1_START]) begin
      evec = job_q.prv;
    end else if (sel[E2_START]) begin
      evec = job_q.cur;
    end else if (sel[STATUS]) begin
      evec = '0;
    end else begin
      evec = xr_q;
    end
    if (sel[E1_CROSS]) begin
      av = job_q.prv;
      da = job_q.prv_dot;
      bv = job_q.cur;
      db = job_q.cur_dot;
    end else begin
      av = job_q.cur;
      da = job_q.cur_dot;
      bv = job_q.fst;
      db = job_q.fst_dot;
    end
  end

  // one restoring division step and the floor of the scaled product
  always_comb begin
    rem_sh = {rem_q, 1'b0};
    take   = rem_sh[ppc_pkg::DOT_W] || (rem_sh[ppc_pkg::DOT_W-1:0] >= den_q);
    qv     = ppc_pkg::COORD_W'(prod_q >>> ppc_pkg::T_W);
  end

  assign q_rd_o             = pop;
  assign res.valid          = vld_q;
  assign res.out_x          = ovec_q[0];
  assign res.out_y          = ovec_q[1];
  assign res.out_z          = ovec_q[2];
  assign res.out_w          = ovec_q[3];
  assign res.vertex_present = pres_q;
  assign res.polygon_done   = done_q;
  assign res.polygon_kept   = kept_q;
  assign res.run_end        = end_q;

  // sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      mask_q  <= '0;
      cnt_q   <= '0;
      xrdy_q  <= 1'b0;
      bit_q   <= '0;
      j_q     <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (emit) begin
        vld_q <= 1'b1;
      end else if (res.ready) begin
        vld_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop) begin
            mask_q <= mask_in;
            xrdy_q <= 1'b0;
            if (!q_data_i.mid) cnt_q <= '0;
            if (mask_in != '0) state_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (need_div) begin
            bit_q   <= '0;
            state_q <= B_DIV;
          end else if (emit) begin
            mask_q <= mask_nxt;
            cnt_q  <= cnt_nxt;
            xrdy_q <= 1'b0;
            if (mask_nxt == '0) state_q <= B_IDLE;
          end
        end
        B_DIV: begin
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'(ppc_pkg::T_W - 1)) begin
            j_q     <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: state_q <= B_ADD;
        B_ADD: begin
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            xrdy_q  <= 1'b1;
            state_q <= B_RUN;
          end else begin
            state_q <= B_MUL;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    if (pop) job_q <= q_data_i;
    if (state_q == B_RUN && need_div) begin
      if (neg(da)) begin
        ov_q  <= av;
        iv_q  <= bv;
        rem_q <= '0 - da;
        den_q <= db - da;
      end else begin
        ov_q  <= bv;
        iv_q  <= av;
        rem_q <= '0 - db;
        den_q <= da - db;
      end
      t_q <= '0;
    end
    if (state_q == B_DIV) begin
      rem_q <= take ? rem_sh[ppc_pkg::DOT_W-1:0] - den_q : rem_sh[ppc_pkg::DOT_W-1:0];
      t_q   <= {t_q[ppc_pkg::T_W-2:0], take};
    end
    if (state_q == B_MUL) begin
      prod_q <= $signed({1'b0, t_q}) *
                ($signed(33'(signed'(iv_q[j_q]))) - $signed(33'(signed'(ov_q[j_q]))));
    end
    if (state_q == B_ADD) begin
      xr_q[j_q] <= ov_q[j_q] + qv;
    end
    if (emit) begin
      ovec_q <= evec;
      pres_q <= pres;
      end_q  <= (mask_nxt == '0);
      done_q <= (mask_nxt == '0) && job_q.fin;
      kept_q <= (mask_nxt == '0) && job_q.fin && (cnt_nxt == 2'd3);
    end
  end

endmodule

>>> src/polygon_plane_clipper.sv
// polygon_plane_clipper: clips a streamed convex polygon against one plane
// depends on ppc_pkg, ppc_if, ppc_front, ppc_queue and ppc_back
//
//   channel  direction  carries
//   vtx_i    in         one vertex request per polygon corner, last one marked
//   cfg_i    in         plane coefficient writes, index 0..3 = a, b, c, d
//   res_o    out        kept vertices, intersections and the polygon status
//
// the front takes one vertex at a time: one 32x32 multiplier is shared by the
// four dot product terms (accumulate, a push that waits for queue room, idle).
// the back emits one vertex per cycle while the result side is free; each
// intersection needs 24 quotient bits, then a multiply and an add per coordinate.
// a two-entry queue lets the front run ahead of the back.
// reset clears the plane, the polygon state and all valid flags; no clearing pass.
`timescale 1ns / 1ps
module polygon_plane_clipper #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ppc_vtx_if.sink  vtx_i,
  ppc_cfg_if.sink  cfg_i,
  ppc_res_if.source res_o
);

  logic          q_wr, q_full, q_rd, q_empty;
  ppc_pkg::job_t q_wdata, q_rdata;

  // classification front
  ppc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vtx      (vtx_i),
    .cfg      (cfg_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_data_o (q_wdata)
  );

  // job queue
  ppc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // edge walker and interpolation back
  ppc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_rd_o    (q_rd),
    .res       (res_o)
  );

  // a status-only result closes both the request and the polygon
  a_status_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.vertex_present) |-> (res_o.polygon_done && res_o.run_end))
    else $error("status result without polygon_done and run_end");

  // kept flag only on the polygon's last result
  a_kept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.polygon_kept) |-> res_o.polygon_done)
    else $error("polygon_kept outside polygon_done");

  // polygon end is always the end of that request's results
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.polygon_done) |-> res_o.run_end)
    else $error("polygon_done without run_end");

  // no job is written into a full queue unless one is read in the same cycle
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> (!q_full || q_rd))
    else $error("job queue overflow");

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for the polygon plane clipper
// depends on ppc_pkg, ppc_if and the polygon_plane_clipper rtl
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned TB = 24;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] x, y, z, w;
    logic        present, done, kept, last;
  } clip_out_t;

  typedef struct {
    logic [31:0] x, y, z, w;
    logic        fin;
    logic        chk;   // expected row given
    clip_out_t   exp0;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppc_vtx_if vtx ();
  ppc_cfg_if cfg ();
  ppc_res_if res ();

  polygon_plane_clipper dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx),
    .cfg_i (cfg),
    .res_o (res)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint    plane_q[4];
  longint    first_v[4], prev_v[4];
  longint    first_d, prev_d;
  bit        in_poly;
  int        kept_cnt;
  clip_out_t clip_q[$];
  clip_out_t burst[$];

  int  n_err, n_res, n_vtx, n_poly, n_cut, n_status;
  bit  quiet;
  longint cyc;

  function automatic longint sat_dot(longint v[4]);
    logic signed [65:0] acc;
    acc = 0;
    for (int k = 0; k < 4; k++)
      acc += 66'(signed'(plane_q[k])) * 66'(signed'(v[k]));
    if (acc > 66'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (acc < -66'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(acc);
  endfunction

  function automatic void emit(longint v[4], bit present);
    clip_out_t r;
    r = '0;
    if (present) begin
      r.x = v[0][31:0]; r.y = v[1][31:0]; r.z = v[2][31:0]; r.w = v[3][31:0];
    end
    r.present = present;
    burst = {burst, r};
    if (present && kept_cnt < 3) kept_cnt++;
  endfunction

  // intersection interpolated from outside end o towards inside end i
  function automatic void cut_point(longint o[4], longint od, longint i[4], longint id);
    logic [63:0] num, den, rem;
    logic        top;
    longint      t, p, q;
    longint      r[4];
    num = -od; den = id + num; rem = num; t = 0;
    for (int b = 0; b < TB; b++) begin
      top = rem[63];
      rem = rem << 1;
      t = t << 1;
      if (top || rem >= den) begin
        rem = rem - den;
        t |= 1;
      end
    end
    for (int j = 0; j < 4; j++) begin
      p = t * (i[j] - o[j]);
      q = p >>> TB;   // arithmetic shift floors
      r[j] = o[j] + q;
    end
    n_cut++;
    emit(r, 1'b1);
  endfunction

  function automatic void clip_edge(longint a[4], longint da, longint b[4], longint db);
    if (da >= 0) emit(a, 1'b1);
    if (da < 0 && db > 0) cut_point(a, da, b, db);
    else if (da > 0 && db < 0) cut_point(b, db, a, da);
  endfunction

  function automatic void predict_vertex(logic [31:0] x, y, z, w, logic fin);
    longint v[4];
    longint d;
    v[0] = longint'(signed'(x)); v[1] = longint'(signed'(y));
    v[2] = longint'(signed'(z)); v[3] = longint'(signed'(w));
    d = sat_dot(v);
    burst.delete();
    if (!in_poly) begin
      first_v = v; first_d = d; kept_cnt = 0;
    end else begin
      clip_edge(prev_v, prev_d, v, d);
    end
    prev_v = v; prev_d = d;
    if (fin) begin
      clip_edge(v, d, first_v, first_d);
      if (burst.size() == 0) begin
        emit(v, 1'b0);
        n_status++;
      end
      burst[$].done = 1'b1;
      burst[$].kept = kept_cnt >= 3;
      in_poly = 1'b0;
      n_poly++;
    end else begin
      in_poly = 1'b1;
    end
    if (burst.size() > 0) burst[$].last = 1'b1;
    clip_q = {clip_q, burst};
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        clip_out_t got, want;
        got = {res.out_x, res.out_y, res.out_z, res.out_w, res.vertex_present,
               res.polygon_done, res.polygon_kept, res.run_end};
        n_res++;
        if (clip_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h", got);
        end else begin
          want = clip_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: expected %h got %h", want, got);
          end
        end
      end
      res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_plane(ppc_pkg::cfg_reg_e idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    plane_q[idx] = longint'(signed'(val));
  endtask

  task automatic set_plane(logic [31:0] a, b, c, d);
    write_plane(ppc_pkg::REG_PLANE_A, a);
    write_plane(ppc_pkg::REG_PLANE_B, b);
    write_plane(ppc_pkg::REG_PLANE_C, c);
    write_plane(ppc_pkg::REG_PLANE_D, d);
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_vertex(logic [31:0] x, y, z, w, logic fin);
    while (!quiet && $urandom_range(99) < 37) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.in_x <= x; vtx.in_y <= y; vtx.in_z <= z; vtx.in_w <= w;
    vtx.final_vertex <= fin;
    do @(posedge clk_i); while (!vtx.ready);
    predict_vertex(x, y, z, w, fin);
    n_vtx++;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(65536 * 4) - 65536 * 2;
      default: return $urandom();
    endcase
  endfunction

  row_t rows[$];

  task automatic add_row(logic [31:0] x, y, z, w, logic fin, logic chk = 0,
                         clip_out_t e = '0);
    row_t r;
    r.x = x; r.y = y; r.z = z; r.w = w; r.fin = fin; r.chk = chk; r.exp0 = e;
    rows = {rows, r};
  endtask

  initial begin
    int sides;
    cyc = 0; n_err = 0; n_res = 0; n_vtx = 0; n_poly = 0; n_cut = 0; n_status = 0;
    quiet = 1'b0; in_poly = 1'b0; kept_cnt = 0;
    foreach (plane_q[k]) plane_q[k] = 0;
    vtx.valid <= 1'b0; vtx.in_x <= '0; vtx.in_y <= '0; vtx.in_z <= '0; vtx.in_w <= '0;
    vtx.final_vertex <= 1'b0;
    cfg.valid <= 1'b0; cfg.index <= ppc_pkg::REG_PLANE_A; cfg.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero plane after reset, every dot is 0 so all inside
    add_row(32'h1, 32'h2, 32'h3, 32'h4, 1'b1, 1'b1,
            '{x: 32'h1, y: 32'h2, z: 32'h3, w: 32'h4, present: 1, done: 1, kept: 0, last: 1});
    foreach (rows[i]) begin
      int before_n;
      before_n = clip_q.size();
      send_vertex(rows[i].x, rows[i].y, rows[i].z, rows[i].w, rows[i].fin);
      if (rows[i].chk && clip_q[before_n] !== rows[i].exp0) begin
        n_err++;
        if (n_err <= 10)
          $display("directed row %0d: predictor %h table %h", i, clip_q[before_n],
                   rows[i].exp0);
      end
    end
    drain();

    // plane w >= 0 style: w coefficient 1.0, x coefficient -1.0 (x <= w)
    set_plane(32'hFFFF_0000, 32'h0, 32'h0, 32'h0001_0000);
    rows.delete();
    // triangle crossing plane, extremes, zero-dot end, single vertex, all outside
    add_row(32'h0, 32'h0, 32'h0, 32'h0001_0000, 0);
    add_row(32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0);
    add_row(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 1);
    add_row(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 0);
    add_row(32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000, 1);
    add_row(32'h0009_0000, 32'h1, 32'h1, 32'h0001_0000, 1);
    add_row(32'h0009_0000, 32'h0, 32'h0, 32'h0, 0);
    add_row(32'h0008_0000, 32'h0, 32'h0, 32'h0, 1);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    foreach (rows[i]) send_vertex(rows[i].x, rows[i].y, rows[i].z, rows[i].w, rows[i].fin);
    drain();

    // extreme plane to exercise dot saturation
    set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    drain();

    // random polygons, new plane between phases
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4)
        set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      else
        set_plane($urandom_range(1) ? rnd_coord() : $urandom_range(131072) - 65536,
                  rnd_coord(), $urandom_range(65536), 32'h0001_0000 * $urandom_range(3));
      quiet = (ph == 2);
      while (n_vtx < 15 + (ph + 1) * 100) begin
        sides = $urandom_range(9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 7);
        for (int s = 0; s < sides; s++)
          send_vertex(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), s == sides - 1);
      end
      vtx.valid <= 1'b0;
      // sender holds off until all results are back
      drain();
    end
    quiet = 1'b0;

    $display("ran %0d vertices in %0d polygons: %0d results, %0d intersections, %0d status",
             n_vtx, n_poly, n_res, n_cut, n_status);
    if (n_err == 0 && clip_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, clip_q.size());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
